[rtl/pipeline_resource_timing_defines.svh]
// Assertion macros for the pipeline resource timing block.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef PIPELINE_RESOURCE_TIMING_DEFINES_SVH
`define PIPELINE_RESOURCE_TIMING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/prt_pkg.sv]
// Shared types and constants for the pipeline resource timing block.
// No dependencies.
package prt_pkg;

  localparam int RESOURCE_COUNT_DEF = 32;
  localparam int STAGE_SLOTS_DEF    = 8;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ENTRY = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic REPLY_FINISH = 1'b0;
  localparam logic REPLY_READ   = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  resource_id;
    logic [15:0] latency_value;
    logic        last_in_stage;
    logic        last_of_instruction;
  } in_item_t;

  typedef struct packed {
    logic        reply_kind;
    logic [63:0] cycle_value;
    logic [63:0] usage_value;
    logic        instruction_done;
  } out_item_t;

endpackage

[rtl/prt_table_ram.sv]
// Per-resource table: one write port, one registered read port.
// Entries never written read as zero (valid bit per entry). No dependencies.
module prt_table_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] data_r;
  logic             ok_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ok_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        ok_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = ok_r ? data_r : '0;

endmodule

[rtl/pipeline_resource_timing.sv]
// Pipeline resource timing: latency / ready-cycle / usage tables per resource.
// Steps: load writes at accept; entry and read go through EXEC; read then EMIT;
//   stage end adds FIN, WALK (one ready-cycle write per cycle per entry; skipped if none is buffered), EMIT.
// Throughput: one item at a time; set by the single 64-bit adder and the
//   single write port of the ready-cycle table. Output register holds a result.
// Reset (rst_n, synchronous, active low): tables read as zero, stage cleared.
module pipeline_resource_timing #(
  parameter int RESOURCE_COUNT = prt_pkg::RESOURCE_COUNT_DEF,
  parameter int STAGE_SLOTS    = prt_pkg::STAGE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  prt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output prt_pkg::out_item_t out_data
);

  localparam int RIDX_W = $clog2(RESOURCE_COUNT);
  localparam int MIDX_W = (STAGE_SLOTS > 1) ? $clog2(STAGE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(STAGE_SLOTS + 1);

  // one-hot sequencer
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,  // table data back: update usage / maxima, or form read reply
    ST_FIN  = 5'b00100,  // finish = max(base) + latency max
    ST_WALK = 5'b01000,  // write finish to each buffered resource
    ST_EMIT = 5'b10000   // hand result to output register
  } state_t;

  state_t               state_r, state_nxt;
  prt_pkg::in_item_t    item_r;
  logic                 hit_r;          // resource id below RESOURCE_COUNT
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     walk_r;
  logic [63:0]          rmax_r;
  logic [15:0]          lmax_r;
  logic [63:0]          prev_r;
  logic                 first_r;
  logic [63:0]          finish_r;
  logic [RIDX_W-1:0]    mbr_q;
  logic [RIDX_W-1:0]    mbr_mem [STAGE_SLOTS];
  prt_pkg::out_item_t   res_r;
  prt_pkg::out_item_t   out_data_r;
  logic                 out_valid_r;

  logic                 in_acc;
  logic                 in_hit;
  logic [RIDX_W-1:0]    in_ridx;
  logic [RIDX_W-1:0]    item_ridx;
  logic                 slot_free;
  logic                 entry_ok;
  logic                 walk_last;
  logic [63:0]          base;
  logic [63:0]          add_a;
  logic [63:0]          add_b;
  logic [63:0]          sum;
  logic [15:0]          lat_rd;
  logic [63:0]          rdy_rd;
  logic [63:0]          use_rd;
  logic                 lat_we;
  logic                 use_we;
  logic                 rdy_we;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_hit    = (32'(in_data.resource_id) < RESOURCE_COUNT);
  assign in_ridx   = RIDX_W'(in_data.resource_id);
  assign item_ridx = RIDX_W'(item_r.resource_id);
  assign slot_free = !out_valid_r || !out_stall;
  assign entry_ok  = hit_r && (cnt_r < CNT_W'(STAGE_SLOTS));
  assign walk_last = (walk_r == cnt_r);

  // chained stages take the later of running max and previous finish
  assign base = (!first_r && (prev_r > rmax_r)) ? prev_r : rmax_r;

  // the one shared 64-bit adder: usage update in EXEC, finish in FIN
  always_comb begin
    if (state_r == ST_FIN) begin
      add_a = base;
      add_b = {48'd0, lmax_r};
    end else begin
      add_a = use_rd;
      add_b = {48'd0, lat_rd};
    end
  end
  assign sum = add_a + add_b;

  assign lat_we = in_acc && (in_data.command == prt_pkg::CMD_LOAD) && in_hit;
  assign use_we = (state_r == ST_EXEC) && (item_r.command == prt_pkg::CMD_ENTRY) && entry_ok;
  assign rdy_we = (state_r == ST_WALK);

  // all three tables are read at accept so data is ready in EXEC
  prt_table_ram #(.DEPTH(RESOURCE_COUNT), .WIDTH(16)) u_lat (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (lat_we),
    .waddr (in_ridx),
    .wdata (in_data.latency_value),
    .re    (in_acc),
    .raddr (in_ridx),
    .rdata (lat_rd)
  );

  prt_table_ram #(.DEPTH(RESOURCE_COUNT), .WIDTH(64)) u_use (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (use_we),
    .waddr (item_ridx),
    .wdata (sum),
    .re    (in_acc),
    .raddr (in_ridx),
    .rdata (use_rd)
  );

  prt_table_ram #(.DEPTH(RESOURCE_COUNT), .WIDTH(64)) u_rdy (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (rdy_we),
    .waddr (mbr_q),
    .wdata (finish_r),
    .re    (in_acc),
    .raddr (in_ridx),
    .rdata (rdy_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && ((in_data.command == prt_pkg::CMD_ENTRY) ||
                       (in_data.command == prt_pkg::CMD_READ))) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (item_r.command == prt_pkg::CMD_READ) begin
          state_nxt = ST_EMIT;
        end else if (item_r.last_in_stage) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FIN: begin
        state_nxt = (cnt_r == '0) ? ST_EMIT : ST_WALK;
      end
      ST_WALK: begin
        if (walk_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // stage member buffer: written in EXEC, walked after FIN
  always_ff @(posedge clk) begin
    if (use_we) begin
      mbr_mem[cnt_r[MIDX_W-1:0]] <= item_ridx;
    end
    if (state_r == ST_FIN) begin
      mbr_q <= mbr_mem[0];
    end else if ((state_r == ST_WALK) && !walk_last) begin
      mbr_q <= mbr_mem[walk_r[MIDX_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
      hit_r  <= in_hit;
    end
    if ((state_r == ST_EXEC) && (item_r.command == prt_pkg::CMD_READ)) begin
      res_r.reply_kind       <= prt_pkg::REPLY_READ;
      res_r.cycle_value      <= hit_r ? rdy_rd : 64'd0;
      res_r.usage_value      <= hit_r ? use_rd : 64'd0;
      res_r.instruction_done <= 1'b0;
    end
    if (state_r == ST_FIN) begin
      finish_r               <= sum;
      res_r.reply_kind       <= prt_pkg::REPLY_FINISH;
      res_r.cycle_value      <= sum;
      res_r.usage_value      <= 64'd0;
      res_r.instruction_done <= item_r.last_of_instruction;
    end
    if ((state_r == ST_EMIT) && slot_free) begin
      out_data_r <= res_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      walk_r      <= '0;
      rmax_r      <= 64'd0;
      lmax_r      <= 16'd0;
      prev_r      <= 64'd0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (use_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (rdy_rd > rmax_r) begin
          rmax_r <= rdy_rd;
        end
        if (lat_rd > lmax_r) begin
          lmax_r <= lat_rd;
        end
      end
      if (state_r == ST_FIN) begin
        walk_r  <= CNT_W'(1);
        rmax_r  <= 64'd0;
        lmax_r  <= 16'd0;
        first_r <= item_r.last_of_instruction;
        prev_r  <= item_r.last_of_instruction ? 64'd0 : sum;
      end
      if ((state_r == ST_WALK) && !walk_last) begin
        walk_r <= walk_r + CNT_W'(1);
      end
      if ((state_r == ST_EMIT) && slot_free && (item_r.command == prt_pkg::CMD_ENTRY)) begin
        cnt_r <= '0;
      end
      if ((state_r == ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/prt_checker.sv]
// Port-level checker for pipeline_resource_timing, bound to the top level.
// Depends on prt_pkg and pipeline_resource_timing_defines.svh.
`include "pipeline_resource_timing_defines.svh"

module prt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input prt_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input prt_pkg::out_item_t out_data
);

  // stalled result holds
  `PRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // an accepted entry or read makes the sequencer busy, so the input is stalled
  `PRT_ASSERT_NEXT(a_busy, in_valid && !in_stall && ((in_data.command == prt_pkg::CMD_ENTRY) || (in_data.command == prt_pkg::CMD_READ)), in_stall, "took next item too early")

  // finish reports carry no usage
  `PRT_ASSERT_NOW(a_fin_usage, out_valid && (out_data.reply_kind == prt_pkg::REPLY_FINISH), out_data.usage_value == 64'd0, "usage in finish report")

  // read replies never flag instruction done
  `PRT_ASSERT_NOW(a_read_done, out_valid && (out_data.reply_kind == prt_pkg::REPLY_READ), !out_data.instruction_done, "done flag on read reply")

endmodule

bind pipeline_resource_timing prt_checker u_prt_checker (.*);

[dv/prt_timing_sb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the pipeline resource timing block: predicts stage finish and read
// replies from accepted items and checks the block's replies against them.
// Depends on prt_pkg for the item types, command codes and table sizes.
package prt_timing_sb_pkg;
  import prt_pkg::*;

  class stage_timing_scoreboard;
    localparam int NRES  = RESOURCE_COUNT_DEF;
    localparam int NSLOT = STAGE_SLOTS_DEF;

    logic [15:0] latency_tab [NRES];
    logic [63:0] ready_tab [NRES];
    logic [63:0] usage_tab [NRES];
    logic [4:0]  stage_ids [NSLOT];
    int unsigned stage_fill;
    logic [63:0] stage_ready_max;
    logic [15:0] stage_lat_max;
    logic [63:0] prev_finish;
    bit          first_stage;
    out_item_t   expected_replies [$];
    int          failures;

    function new();
      for (int i = 0; i < NRES; i++) begin
        latency_tab[i] = '0;
        ready_tab[i]   = '0;
        usage_tab[i]   = '0;
      end
      stage_fill      = 0;
      stage_ready_max = '0;
      stage_lat_max   = '0;
      prev_finish     = '0;
      first_stage     = 1'b1;
      failures        = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Accepted input item: update the shadow tables, queue any reply it causes.
    function void note_item(in_item_t it);
      out_item_t   reply;
      logic [63:0] base;
      logic [63:0] finish;
      int          id;
      id = int'(it.resource_id);
      case (it.command)
        CMD_LOAD: begin
          if (id < NRES) latency_tab[id] = it.latency_value;
        end
        CMD_ENTRY: begin
          if (id < NRES && stage_fill < NSLOT) begin
            usage_tab[id] += {48'b0, latency_tab[id]};
            if (ready_tab[id] > stage_ready_max) stage_ready_max = ready_tab[id];
            if (latency_tab[id] > stage_lat_max) stage_lat_max = latency_tab[id];
            stage_ids[stage_fill] = it.resource_id;
            stage_fill++;
          end
          if (it.last_in_stage) begin
            base = stage_ready_max;
            if (!first_stage && prev_finish > base) base = prev_finish;
            finish = base + {48'b0, stage_lat_max};
            for (int k = 0; k < stage_fill; k++) ready_tab[stage_ids[k]] = finish;
            reply.reply_kind       = REPLY_FINISH;
            reply.cycle_value      = finish;
            reply.usage_value      = '0;
            reply.instruction_done = it.last_of_instruction;
            expected_replies.push_back(reply);
            stage_fill      = 0;
            stage_ready_max = '0;
            stage_lat_max   = '0;
            first_stage     = it.last_of_instruction;
            prev_finish     = it.last_of_instruction ? 64'd0 : finish;
          end
        end
        CMD_READ: begin
          reply.reply_kind       = REPLY_READ;
          reply.cycle_value      = (id < NRES) ? ready_tab[id] : 64'd0;
          reply.usage_value      = (id < NRES) ? usage_tab[id] : 64'd0;
          reply.instruction_done = 1'b0;
          expected_replies.push_back(reply);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Accepted reply: compare with the oldest prediction.
    function void check_reply(out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        $display("%0t: unexpected reply: expected none, actual kind %0b cycle %0h %s",
                 $time, got.reply_kind, got.cycle_value,
                 $sformatf("usage %0h done %0b", got.usage_value, got.instruction_done));
      end else begin
        want = expected_replies.pop_front();
        compare_field("reply_kind", {63'b0, want.reply_kind}, {63'b0, got.reply_kind});
        compare_field("cycle_value", want.cycle_value, got.cycle_value);
        compare_field("usage_value", want.usage_value, got.usage_value);
        compare_field("instruction_done", {63'b0, want.instruction_done},
                      {63'b0, got.instruction_done});
      end
    endfunction
  endclass

endpackage

[dv/tb_pipeline_resource_timing.sv]
`timescale 1ns / 100ps
// Top-level testbench for pipeline_resource_timing: directed and random item streams,
// random idling on both channels, one long receiver hold-off, and a watchdog.
// Depends on prt_pkg and prt_timing_sb_pkg.
module tb_pipeline_resource_timing;
  import prt_pkg::*;
  import prt_timing_sb_pkg::*;

  localparam int TOTAL_ITEMS   = 550;  // counted items, command 3 excluded
  localparam int QUIET_FROM    = 480;  // no idling on either side beyond this
  localparam int HOLDOFF_AT    = 120;  // where the long receiver hold-off starts
  localparam int HOLDOFF_LEN   = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES  = 40;   // worst stage end walks all 8 buffered entries

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  stage_timing_scoreboard sb;
  int  items_sent;
  bit  holdoff_done;
  int  idle_cycles;

  // Idling is switched off in every fourth window of 60 items and in the tail.
  wire calm  = ((items_sent / 60) % 4) == 3;
  wire quiet = items_sent >= QUIET_FROM;

  pipeline_resource_timing dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic in_item_t mk_item(logic [1:0] cmd, logic [4:0] id, logic [15:0] lat,
                                       logic ls, logic li);
    in_item_t it;
    it.command             = cmd;
    it.resource_id         = id;
    it.latency_value       = lat;
    it.last_in_stage       = ls;
    it.last_of_instruction = li;
    return it;
  endfunction

  // Mostly small latencies so finish cycles stay readable, with full-range ones mixed in.
  function automatic logic [15:0] rand_latency();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 64));
  endfunction

  // Called just after a falling edge. Optionally idles, then offers the item and
  // holds it steady until the block takes it; returns just after the next falling edge.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    if (it.command != CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  // A load, a read or an unused command, all with random content.
  task automatic send_side_item();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5)
      send_item(mk_item(CMD_LOAD, 5'($urandom), rand_latency(), 1'($urandom), 1'($urandom)));
    else if (pick < 9)
      send_item(mk_item(CMD_READ, 5'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)));
    else
      send_item(mk_item(CMD_NONE, 5'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  // One well-formed instruction: 1 to 4 stages, mostly within the stage capacity,
  // now and then overflowing it; loads, reads or unused commands may fall between entries.
  task automatic run_instruction();
    int  stages;
    int  entries;
    logic ls;
    logic li;
    stages = $urandom_range(1, 4);
    for (int s = 0; s < stages; s++) begin
      entries = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      for (int e = 0; e < entries; e++) begin
        if ($urandom_range(0, 9) == 0) send_side_item();
        ls = (e == entries - 1);
        // last_of_instruction only matters on the stage's final entry
        li = ls ? (s == stages - 1) : 1'($urandom);
        send_item(mk_item(CMD_ENTRY, 5'($urandom), 16'($urandom), ls, li));
      end
    end
  endtask

  // Receiver side: random stall bursts, one long hold-off while the sender keeps
  // offering items so the block backs up, and none at all in the tail.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!holdoff_done && items_sent >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        stall_left   = HOLDOFF_LEN - 1;
        out_stall    <= 1'b1;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Replies are taken at the rising edge where valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_data);
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_pipeline_resource_timing NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb           = new();
    items_sent   = 0;
    holdoff_done = 1'b0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reads of untouched tables at both ends of the resource range,
    // an unused command, latency extremes.
    send_item(mk_item(CMD_READ, 5'd0, 16'h0000, 1'b0, 1'b0));
    send_item(mk_item(CMD_READ, 5'd31, 16'hFFFF, 1'b1, 1'b1));
    send_item(mk_item(CMD_NONE, 5'd5, 16'hFFFF, 1'b1, 1'b1));
    send_item(mk_item(CMD_LOAD, 5'd0, 16'hFFFF, 1'b0, 1'b0));
    send_item(mk_item(CMD_LOAD, 5'd31, 16'h0001, 1'b1, 1'b1));
    send_item(mk_item(CMD_LOAD, 5'd10, 16'h5A5A, 1'b0, 1'b0));
    send_item(mk_item(CMD_LOAD, 5'd21, 16'h0000, 1'b0, 1'b0));
    // First stage of an instruction: no predecessor, finish = 0 + 0xFFFF.
    send_item(mk_item(CMD_ENTRY, 5'd0, 16'h0000, 1'b0, 1'b1));
    send_item(mk_item(CMD_ENTRY, 5'd31, 16'hFFFF, 1'b1, 1'b0));
    // Second stage chains on the first; latency of r10 changes mid-stage and a
    // read lands inside the stage.
    send_item(mk_item(CMD_ENTRY, 5'd10, 16'h0000, 1'b0, 1'b0));
    send_item(mk_item(CMD_LOAD, 5'd10, 16'h00A5, 1'b0, 1'b0));
    send_item(mk_item(CMD_ENTRY, 5'd10, 16'h0000, 1'b0, 1'b0));
    send_item(mk_item(CMD_READ, 5'd10, 16'h0000, 1'b0, 1'b0));
    send_item(mk_item(CMD_ENTRY, 5'd21, 16'h0000, 1'b1, 1'b1));
    send_item(mk_item(CMD_READ, 5'd0, 16'h0000, 1'b0, 1'b0));
    // Stage overflow: eight entries fill the stage, the ninth is dropped but its
    // last_in_stage still closes the stage.
    for (int k = 0; k < 8; k++) begin
      case (k % 4)
        0: send_item(mk_item(CMD_ENTRY, 5'd0, 16'h0000, 1'b0, 1'b0));
        1: send_item(mk_item(CMD_ENTRY, 5'd31, 16'h0000, 1'b0, 1'b0));
        2: send_item(mk_item(CMD_ENTRY, 5'd10, 16'h0000, 1'b0, 1'b0));
        default: send_item(mk_item(CMD_ENTRY, 5'd21, 16'h0000, 1'b0, 1'b0));
      endcase
    end
    send_item(mk_item(CMD_ENTRY, 5'd0, 16'h0000, 1'b1, 1'b1));
    send_item(mk_item(CMD_READ, 5'd31, 16'h0000, 1'b0, 1'b0));
    send_item(mk_item(CMD_READ, 5'd0, 16'h0000, 1'b0, 1'b0));

    // Random part: mostly whole instructions, the rest loose loads, reads, noise.
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 7) run_instruction();
      else send_side_item();
    end
    in_valid <= 1'b0;

    // Drain, then allow for the block's worst stage-end latency.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_pipeline_resource_timing OK");
    end else begin
      $display("tb_pipeline_resource_timing NOT OK");
    end
    $finish;
  end

endmodule
